/* design/pttt_pkg.sv */
// ----------------------------------------------------------------------------
// pttt_pkg
// Shared opcodes, status codes and the command record for the task timer.
// ----------------------------------------------------------------------------
package pttt_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_DELETE   = 3'd1,
    OP_DEL_ALL  = 3'd2,
    OP_TICK     = 3'd3,
    OP_DISPATCH = 3'd4
  } opcode_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_IDX = 2'd3;

  localparam int MAX_RUNS = 16;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] task_handle;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [7:0]  slot_id;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_ACK
  } back_state_t;

endpackage

/* design/pttt_front.sv */
// ----------------------------------------------------------------------------
// pttt_front
// Accepts command beats into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pttt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  pttt_pkg::cmd_t cmd_in,
  output logic          q_valid,
  output pttt_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import pttt_pkg::*;

  cmd_t       entry [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) entry[wr_ptr] <= cmd_in;
  end

endmodule

/* design/pttt_back.sv */
// ----------------------------------------------------------------------------
// pttt_back
// Slot table and sequencer: sweeps the slots one per cycle for tick and dispatch.
// ----------------------------------------------------------------------------
module pttt_back #(
  parameter int SLOT_COUNT = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pttt_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           result_valid,
  output logic           result_kind,
  output logic [1:0]     status,
  output logic [3:0]     slot_index,
  output logic [15:0]    run_handle,
  output logic [4:0]     task_count,
  output logic [1:0]     last_error,
  output logic [31:0]    tick_time,
  output logic           last
);
  import pttt_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [15:0] slot_handle  [SLOT_COUNT];
  logic [31:0] slot_delay   [SLOT_COUNT];
  logic [31:0] slot_period  [SLOT_COUNT];
  logic [7:0]  slot_pending [SLOT_COUNT];
  logic [CW-1:0] used_count;
  logic [1:0]  error_record;
  logic [31:0] tick_counter;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [IW:0] idx;
  logic [4:0]  runs;
  logic [IW-1:0] sel;
  logic        found;
  logic [IW-1:0] free_idx;

  assign sel = idx[IW-1:0];

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_handle[i] == 16'd0) begin
        found    = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic sweep_done;
  logic serv;
  assign sweep_done = (idx == (IW+1)'(SLOT_COUNT - 1));
  assign serv = (slot_pending[sel] != 8'd0) && (slot_handle[sel] != 16'd0) &&
                (runs < 5'(MAX_RUNS));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.opcode == OP_TICK || q_cmd.opcode == OP_DISPATCH)
            state_next = BK_SWEEP;
          else
            state_next = BK_ACK;
        end
      end
      BK_SWEEP: if (sweep_done) state_next = BK_ACK;
      BK_ACK:   state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign q_pop = (state == BK_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      used_count   <= '0;
      error_record <= ST_OK;
      tick_counter <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_handle[i]  <= '0;
        slot_pending[i] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        BK_IDLE: begin
          result_valid <= 1'b0;
          if (q_valid) begin
            cur        <= q_cmd;
            idx        <= '0;
            runs       <= '0;
            if (q_cmd.opcode == OP_TICK) tick_counter <= tick_counter + 32'd1;
          end
        end
        BK_SWEEP: begin
          idx <= idx + 1'b1;
          if (cur.opcode == OP_TICK) begin
            result_valid <= 1'b0;
            if (slot_handle[sel] != 16'd0) begin
              if (slot_delay[sel] != 32'd0) begin
                slot_delay[sel] <= slot_delay[sel] - 32'd1;
              end else begin
                if (slot_pending[sel] != 8'hFF)
                  slot_pending[sel] <= slot_pending[sel] + 8'd1;
                if (slot_period[sel] != 32'd0)
                  slot_delay[sel] <= slot_period[sel];
              end
            end
          end else begin
            result_valid <= serv;
            if (serv) begin
              runs         <= runs + 5'd1;
              result_kind  <= 1'b1;
              status       <= ST_OK;
              slot_index   <= 4'(sel);
              run_handle   <= slot_handle[sel];
              last_error   <= error_record;
              tick_time    <= tick_counter;
              last         <= 1'b0;
              if (slot_period[sel] == 32'd0) begin
                slot_handle[sel]  <= '0;
                slot_pending[sel] <= '0;
                slot_delay[sel]   <= '0;
                used_count        <= used_count - 1'b1;
                task_count        <= 5'(used_count - 1'b1);
              end else begin
                slot_pending[sel] <= slot_pending[sel] - 8'd1;
                task_count        <= 5'(used_count);
              end
            end
          end
        end
        BK_ACK: begin
          if (cur.opcode == OP_DISPATCH && runs != 5'd0) begin
            result_valid <= 1'b1;
            result_kind  <= 1'b1;
            last         <= 1'b1;
          end else begin
            logic [1:0] st;
            logic [3:0] sl;
            logic [CW-1:0] uc;
            st = ST_OK;
            sl = '0;
            uc = used_count;
            unique case (cur.opcode)
              OP_ADD: begin
                if (cur.task_handle == 16'd0) st = ST_NULL;
                else if (used_count >= CW'(SLOT_COUNT) || !found) st = ST_FULL;
                else begin
                  slot_handle[free_idx]  <= cur.task_handle;
                  slot_delay[free_idx]   <= cur.first_delay;
                  slot_period[free_idx]  <= cur.repeat_period;
                  slot_pending[free_idx] <= '0;
                  uc = used_count + 1'b1;
                  sl = 4'(free_idx);
                end
              end
              OP_DELETE: begin
                if (cur.slot_id >= 8'(SLOT_COUNT) ||
                    slot_handle[cur.slot_id[IW-1:0]] == 16'd0) st = ST_BAD_IDX;
                else begin
                  slot_handle[cur.slot_id[IW-1:0]]  <= '0;
                  slot_pending[cur.slot_id[IW-1:0]] <= '0;
                  slot_delay[cur.slot_id[IW-1:0]]   <= '0;
                  slot_period[cur.slot_id[IW-1:0]]  <= '0;
                  uc = used_count - 1'b1;
                end
              end
              OP_DEL_ALL: begin
                if (used_count == '0) st = ST_BAD_IDX;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                  slot_handle[i]  <= '0;
                  slot_pending[i] <= '0;
                  slot_delay[i]   <= '0;
                  slot_period[i]  <= '0;
                end
                uc = '0;
              end
              default: ;
            endcase
            used_count   <= uc;
            if (st != ST_OK) error_record <= st;
            result_valid <= 1'b1;
            result_kind  <= 1'b0;
            status       <= st;
            slot_index   <= sl;
            run_handle   <= '0;
            task_count   <= 5'(uc);
            last_error   <= (st != ST_OK) ? st : error_record;
            tick_time    <= tick_counter;
            last         <= 1'b1;
          end
        end
        default: result_valid <= 1'b0;
      endcase
    end
  end

endmodule

/* design/periodic_task_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Time-triggered task table with add, delete, delete-all, tick and dispatch.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; a two-entry
// queue sits in front of the slot sequencer, so busy rises only when it fills.
// Add, delete and delete-all go from idle straight to the acknowledge state in
// the back end; tick and dispatch first sweep the table one slot per cycle.
// An acknowledge passes through the back end's result register and then the
// output register before it reaches the ports.
// Results appear with result_valid high for one cycle each; the receiver
// cannot stall. Dispatch gives one run beat per serviced slot, and each run
// beat is held until the next beat from the back end shows whether it is the
// final one, so the final run beat goes out when the back end's last beat arrives.
// Reset frees every slot and clears the counters and the error record at once.
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [15:0] task_handle,
  input  logic [31:0] first_delay,
  input  logic [31:0] repeat_period,
  input  logic [7:0]  slot_id,
  output logic        result_valid,
  output logic        result_kind,
  output logic [1:0]  status,
  output logic [3:0]  slot_index,
  output logic [15:0] run_handle,
  output logic [4:0]  task_count,
  output logic [1:0]  last_error,
  output logic [31:0] tick_time,
  output logic        last
);
  import pttt_pkg::*;

  cmd_t cmd_in, q_cmd;
  logic q_valid, q_pop;
  logic       b_valid, b_kind, b_last;
  logic [1:0] b_status, b_err;
  logic [3:0] b_slot;
  logic [15:0] b_handle;
  logic [4:0] b_count;
  logic [31:0] b_time;
  logic       hold;
  logic [3:0] h_slot;
  logic [15:0] h_handle;
  logic [4:0] h_count;
  logic [1:0] h_err;
  logic [31:0] h_time;

  assign cmd_in = '{opcode: opcode, task_handle: task_handle,
                    first_delay: first_delay, repeat_period: repeat_period,
                    slot_id: slot_id};

  pttt_front u_front (
    .clk, .rst, .start, .busy, .cmd_in,
    .q_valid, .q_cmd, .q_pop
  );

  pttt_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop,
    .result_valid(b_valid), .result_kind(b_kind), .status(b_status),
    .slot_index(b_slot), .run_handle(b_handle), .task_count(b_count),
    .last_error(b_err), .tick_time(b_time), .last(b_last)
  );

  // A run beat is held until the next beat shows whether it is the final one.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold         <= 1'b0;
      result_valid <= 1'b0;
    end else if (b_valid && b_kind) begin
      result_valid <= hold;
      result_kind  <= 1'b1;
      status       <= ST_OK;
      slot_index   <= h_slot;
      run_handle   <= h_handle;
      task_count   <= h_count;
      last_error   <= h_err;
      tick_time    <= h_time;
      last         <= b_last;
      if (b_last) begin
        hold <= 1'b0;
      end else begin
        hold     <= 1'b1;
        h_slot   <= b_slot;
        h_handle <= b_handle;
        h_count  <= b_count;
        h_err    <= b_err;
        h_time   <= b_time;
      end
    end else if (b_valid) begin
      result_valid <= 1'b1;
      last         <= b_last;
      result_kind  <= b_kind;
      status       <= b_status;
      slot_index   <= b_slot;
      run_handle   <= b_handle;
      task_count   <= b_count;
      last_error   <= b_err;
      tick_time    <= b_time;
    end else begin
      result_valid <= 1'b0;
    end
  end

endmodule
